// ===== hdl/ucs_pkg.sv =====
// Shared types and constants for the UDP/IPv4 checksum engine.
`timescale 1ns / 1ps

package ucs_pkg;

    // One segment byte with its side fields
    typedef struct packed {
        logic        mode;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  data_byte;
        logic        last_byte;
    } ucs_in_t;

    // One finished checksum result
    typedef struct packed {
        logic [15:0] checksum;
        logic        checksum_ok;
    } ucs_out_t;

    // End-of-segment operands handed from the byte accumulator to the fold stage
    typedef struct packed {
        logic [15:0] run_sum;
        logic [15:0] word;
        logic [17:0] addr_sum;
        logic [15:0] seg_len;
        logic        verify;
        logic        long_enough;
        logic        wire_zero;
    } ucs_seg_end_t;

    localparam int          TOTAL_W     = 19;
    localparam logic [15:0] PROTO_UDP   = 16'd17;
    localparam logic [15:0] MIN_SEG_LEN = 16'd8;
    localparam logic [15:0] WIRE_HI_IDX = 16'd6;
    localparam logic [15:0] WIRE_LO_IDX = 16'd7;
    localparam logic [15:0] CKSUM_ZERO  = 16'h0000;
    localparam logic [15:0] CKSUM_ONES  = 16'hFFFF;

endpackage

// ===== hdl/udp_ipv4_checksum_engine_unit.sv =====
// Top level of the UDP/IPv4 checksum engine: input register, accumulator, fold stage.
`timescale 1ns / 1ps

// Usage
//   byte channel: one UDP segment byte per item, in wire order. mode, src_ip and
//   dst_ip are sampled on the first byte of a segment only; last_byte marks the
//   final byte, after which the next item starts a new segment.
//   sum channel: exactly one item per segment, issued for its last byte.
//     generate (mode 0): checksum to place on the wire, 0 sent as 0xFFFF, ok = 1.
//     verify (mode 1): folded inverted sum; ok = 0 under 8 bytes, ok = 1 if the
//     wire checksum (bytes 6-7) is zero, else ok when the sum folds to zero.
// Throughput: one byte per cycle, including back-to-back segments, unless the sum channel stalls.
//   The per-byte loop is one end-around-carry add on the running sum.
// Path: a last byte passes the input register, accumulator end register,
//   wide-sum register and output register before its result is valid.
// Stall: each stage holds its item while the next is full; byte_ready only drops
//   when a last byte cannot hand over to a full fold pipeline.
// Reset: rst_n (async, active low) empties all stages and waits for a first byte.

module udp_ipv4_checksum_engine_unit
    import ucs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  ucs_in_t  byte_item,
    output logic     sum_valid,
    input  logic     sum_ready,
    output ucs_out_t sum_item
);

    logic         in_vld_reg;
    ucs_in_t      in_reg;
    logic         acc_ready;
    logic         end_valid;
    logic         end_ready;
    ucs_seg_end_t end_info;

    // Input register refills in the same cycle it drains
    assign byte_ready = !in_vld_reg || acc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (byte_ready)
            in_vld_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
            in_reg <= byte_item;
    end

    ucs_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .in_item   (in_reg),
        .in_ready  (acc_ready),
        .end_valid (end_valid),
        .end_ready (end_ready),
        .end_info  (end_info)
    );

    ucs_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .end_valid (end_valid),
        .end_info  (end_info),
        .end_ready (end_ready),
        .res_valid (sum_valid),
        .res_ready (sum_ready),
        .res_item  (sum_item)
    );

endmodule

// ===== hdl/ucs_accum.sv =====
// Per-byte segment state: word pairing, running sum, byte count, wire checksum capture.
`timescale 1ns / 1ps

module ucs_accum
    import ucs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  ucs_in_t      in_item,
    output logic         in_ready,
    output logic         end_valid,
    input  logic         end_ready,
    output ucs_seg_end_t end_info
);

    logic         in_seg_reg;
    logic         mode_reg;
    logic [17:0]  addr_sum_reg;
    logic [15:0]  run_reg;
    logic [15:0]  cnt_reg;
    logic         long_reg;
    logic [7:0]   pend_reg;
    logic         odd_reg;
    logic [15:0]  wire_reg;
    logic         end_vld_reg;
    ucs_seg_end_t end_reg;

    logic         first;
    logic         go;
    logic         end_free;
    logic [15:0]  eff_run;
    logic [15:0]  eff_cnt;
    logic         eff_long;
    logic [7:0]   eff_pend;
    logic         eff_odd;
    logic [15:0]  eff_wire;
    logic         mode_eff;
    logic [17:0]  addr_new;
    logic [17:0]  addr_eff;
    logic [15:0]  cnt_next;
    logic         long_next;
    logic [15:0]  wire_next;
    logic [15:0]  pair_word;
    logic [16:0]  pair_t;
    logic [15:0]  run_pair;
    logic [15:0]  tail_word;
    logic [7:0]   b;

    always_comb
    begin
        b        = in_item.data_byte;
        first    = !in_seg_reg;
        // A new segment starts from cleared state
        eff_run  = first ? 16'd0 : run_reg;
        eff_cnt  = first ? 16'd0 : cnt_reg;
        eff_long = first ? 1'b0  : long_reg;
        eff_pend = first ? 8'd0  : pend_reg;
        eff_odd  = first ? 1'b0  : odd_reg;
        eff_wire = first ? 16'd0 : wire_reg;
        mode_eff = first ? in_item.mode : mode_reg;

        addr_new = {2'b00, in_item.src_ip[31:16]} + {2'b00, in_item.src_ip[15:0]}
                 + {2'b00, in_item.dst_ip[31:16]} + {2'b00, in_item.dst_ip[15:0]};
        addr_eff = first ? addr_new : addr_sum_reg;

        cnt_next  = eff_cnt + 16'd1;
        long_next = eff_long || (cnt_next >= MIN_SEG_LEN);

        wire_next = eff_wire;
        if (!eff_long)
        begin
            if (eff_cnt == WIRE_HI_IDX)
                wire_next[15:8] = b;
            else if (eff_cnt == WIRE_LO_IDX)
                wire_next[7:0] = b;
        end

        pair_word = {eff_pend, b};
        pair_t    = {1'b0, eff_run} + {1'b0, pair_word};
        run_pair  = pair_t[15:0] + {15'd0, pair_t[16]};
        // Last byte: either closes a pair or is an odd byte padded with zero
        tail_word = eff_odd ? pair_word : {b, 8'h00};

        end_free = !end_vld_reg || end_ready;
        in_ready = !in_item.last_byte || end_free;
        go       = in_valid && in_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seg_reg  <= 1'b0;
            end_vld_reg <= 1'b0;
        end
        else
        begin
            if (go)
                in_seg_reg <= !in_item.last_byte;
            if (go && in_item.last_byte)
                end_vld_reg <= 1'b1;
            else if (end_ready)
                end_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mode_reg     <= mode_eff;
            addr_sum_reg <= addr_eff;
            cnt_reg      <= cnt_next;
            long_reg     <= long_next;
            wire_reg     <= wire_next;
            if (!eff_odd)
            begin
                pend_reg <= b;
                odd_reg  <= 1'b1;
                run_reg  <= eff_run;
            end
            else
            begin
                pend_reg <= eff_pend;
                odd_reg  <= 1'b0;
                run_reg  <= run_pair;
            end
            if (in_item.last_byte)
            begin
                end_reg.run_sum     <= eff_run;
                end_reg.word        <= tail_word;
                end_reg.addr_sum    <= addr_eff;
                end_reg.seg_len     <= cnt_next;
                end_reg.verify      <= mode_eff;
                end_reg.long_enough <= long_next;
                end_reg.wire_zero   <= (wire_next == CKSUM_ZERO);
            end
        end
    end

    assign end_valid = end_vld_reg;
    assign end_info  = end_reg;

endmodule

// ===== hdl/ucs_fold.sv =====
// End-of-segment sum, one's-complement fold, invert and pass/fail decision.
`timescale 1ns / 1ps

module ucs_fold
    import ucs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         end_valid,
    input  ucs_seg_end_t end_info,
    output logic         end_ready,
    output logic         res_valid,
    input  logic         res_ready,
    output ucs_out_t     res_item
);

    logic               tot_vld_reg;
    logic [TOTAL_W-1:0] tot_reg;
    logic               verify_reg;
    logic               long_reg;
    logic               wzero_reg;
    logic               out_vld_reg;
    ucs_out_t           out_reg;

    logic               out_free;
    logic               tot_free;
    logic [TOTAL_W-1:0] total;
    logic [16:0]        f1;
    logic [15:0]        f2;
    logic [15:0]        res;
    ucs_out_t           out_next;

    always_comb
    begin
        out_free  = !out_vld_reg || res_ready;
        tot_free  = !tot_vld_reg || out_free;
        end_ready = tot_free;

        // Plain wide sum; folding later gives the same residue mod 0xFFFF
        total = TOTAL_W'(end_info.run_sum) + TOTAL_W'(end_info.word)
              + TOTAL_W'(end_info.addr_sum) + TOTAL_W'(end_info.seg_len)
              + TOTAL_W'(PROTO_UDP);

        f1  = {1'b0, tot_reg[15:0]} + {14'd0, tot_reg[TOTAL_W-1:16]};
        f2  = f1[15:0] + {15'd0, f1[16]};
        res = ~f2;

        if (!verify_reg)
        begin
            out_next.checksum    = (res == CKSUM_ZERO) ? CKSUM_ONES : res;
            out_next.checksum_ok = 1'b1;
        end
        else
        begin
            out_next.checksum    = res;
            out_next.checksum_ok = long_reg && (wzero_reg || (res == CKSUM_ZERO));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (tot_free)
                tot_vld_reg <= end_valid;
            if (out_free)
                out_vld_reg <= tot_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tot_free && end_valid)
        begin
            tot_reg    <= total;
            verify_reg <= end_info.verify;
            long_reg   <= end_info.long_enough;
            wzero_reg  <= end_info.wire_zero;
        end
        if (out_free && tot_vld_reg)
            out_reg <= out_next;
    end

    assign res_valid = out_vld_reg;
    assign res_item  = out_reg;

endmodule

// ===== tb/udp_ipv4_checksum_engine_unit_tb.sv =====
// Self-checking testbench for the UDP/IPv4 checksum engine top level.
`timescale 1ns / 1ps

module udp_ipv4_checksum_engine_unit_tb;
    import ucs_pkg::*;

    // ------------------------------------------------------------------
    // Timing
    // ------------------------------------------------------------------
    localparam int CLK_HALF_NS = 2;          // 4 ns period
    localparam int TIMEOUT_NS  = 1_000_000;  // hard stop, several times the slowest run
    localparam int HOLD_CYCLES = 400;        // one long receiver back-off
    localparam int RAND_BYTES  = 375;        // random bytes after the directed rows
    localparam int PAUSE_AT    = 250;        // random bytes before the sender pause
    localparam int DRAIN_PAD   = 8;          // idle pad after the last result

    // mode codes carried on the first byte of a segment
    localparam logic MODE_GEN    = 1'b0;
    localparam logic MODE_VERIFY = 1'b1;

    // ------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------
    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     byte_valid = 1'b0;
    logic     byte_ready;
    ucs_in_t  byte_item  = '0;
    logic     sum_valid;
    logic     sum_ready  = 1'b0;
    ucs_out_t sum_item;

    udp_ipv4_checksum_engine_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .sum_valid  (sum_valid),
        .sum_ready  (sum_ready),
        .sum_item   (sum_item)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // ------------------------------------------------------------------
    // Scoreboard storage
    // ------------------------------------------------------------------
    ucs_out_t    sum_expect_q[$];   // checksums still owed by the DUT, oldest first
    logic [7:0]  seg_bytes[$];      // segment currently being built for the sender
    int          fail_count   = 0;
    int          results_seen = 0;

    // ------------------------------------------------------------------
    // Directed table. Each row is one byte item; rows that close a
    // segment carry a hand-computed checksum (all of them are simple
    // enough to work out on paper: zero and all-ones addresses, the
    // zero-sent-as-ones rule, short verify, a valid 8-byte header and a
    // header with a zero wire checksum). Non-first bytes carry junk
    // mode/address values that the engine must ignore.
    // ------------------------------------------------------------------
    typedef struct packed {
        ucs_in_t  item;
        logic     typed;
        ucs_out_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 23;

    dir_row_t dir_table [DIR_ROWS] = '{
        // single zero byte, generate: 0x11 + len 1 -> ~0x0012
        {MODE_GEN,    32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1, 1'b1, 16'hFFED, 1'b1},
        // single 0xFF byte, all-ones addresses
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 16'h00ED, 1'b1},
        // single byte, verify: too short, sum still reported
        {MODE_VERIFY, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b1, 1'b1, 16'hFFED, 1'b0},
        // word 0xFFEC folds to 0xFFFF: generate sends 0xFFFF instead of 0
        {MODE_GEN,    32'h0000_0000, 32'h0000_0000, 8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_VERIFY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hEC, 1'b1, 1'b1, 16'hFFFF, 1'b1},
        // same bytes in verify: raw zero, but short
        {MODE_VERIFY, 32'h0000_0000, 32'h0000_0000, 8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'h1234_5678, 32'h9ABC_DEF0, 8'hEC, 1'b1, 1'b1, 16'h0000, 1'b0},
        // 8-byte header, length 8, wire checksum 0xFFDE: folds to zero
        {MODE_VERIFY, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h08, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hDE, 1'b1, 1'b1, 16'h0000, 1'b1},
        // 8-byte header with zero wire checksum: accepted, sum still reported
        {MODE_VERIFY, 32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h08, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        {MODE_GEN,    32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h00, 1'b1, 1'b1, 16'hFFDE, 1'b1}
    };

    // ------------------------------------------------------------------
    // Checksum predictor state (mirror of the engine's segment state)
    // ------------------------------------------------------------------
    logic [15:0] acc_sum      = '0;   // one's-complement sum of full words
    logic [15:0] seg_count    = '0;   // bytes so far, wraps at 16 bits
    logic        seg_long     = 1'b0; // sticky: count has reached 8
    logic [7:0]  held_hi      = '0;   // high byte waiting for its partner
    logic        hi_waiting   = 1'b0;
    logic [15:0] seen_wire_cs = '0;   // bytes 6-7 as received
    logic        seg_open     = 1'b0; // 0 = next byte starts a segment
    logic        seg_verify   = 1'b0;
    logic [31:0] seg_src      = '0;
    logic [31:0] seg_dst      = '0;

    // 16-bit add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // Advance the predictor by one accepted byte; a last byte yields a result.
    task automatic predict_byte(input ucs_in_t it, output logic produced,
                                output ucs_out_t res);
        logic [15:0] acc;
        logic [15:0] cs;
        if (!seg_open)
        begin
            seg_verify   = it.mode;
            seg_src      = it.src_ip;
            seg_dst      = it.dst_ip;
            acc_sum      = '0;
            seg_count    = '0;
            seg_long     = 1'b0;
            held_hi      = '0;
            hi_waiting   = 1'b0;
            seen_wire_cs = '0;
            seg_open     = 1'b1;
        end
        // wire checksum is only taken before the count first reaches 8
        if (!seg_long)
        begin
            if (seg_count == WIRE_HI_IDX)
                seen_wire_cs[15:8] = it.data_byte;
            else if (seg_count == WIRE_LO_IDX)
                seen_wire_cs[7:0] = it.data_byte;
        end
        seg_count = seg_count + 16'd1;
        if (seg_count >= MIN_SEG_LEN)
            seg_long = 1'b1;
        if (!hi_waiting)
        begin
            held_hi    = it.data_byte;
            hi_waiting = 1'b1;
        end
        else
        begin
            acc_sum    = ones_add(acc_sum, {held_hi, it.data_byte});
            hi_waiting = 1'b0;
        end

        produced = it.last_byte;
        res      = '0;
        if (it.last_byte)
        begin
            acc = acc_sum;
            if (hi_waiting)
                acc = ones_add(acc, {held_hi, 8'h00});   // odd tail, zero pad
            acc = ones_add(acc, seg_src[31:16]);
            acc = ones_add(acc, seg_src[15:0]);
            acc = ones_add(acc, seg_dst[31:16]);
            acc = ones_add(acc, seg_dst[15:0]);
            acc = ones_add(acc, PROTO_UDP);
            acc = ones_add(acc, seg_count);
            cs  = ~acc;
            if (seg_verify == MODE_GEN)
            begin
                if (cs == CKSUM_ZERO)
                    cs = CKSUM_ONES;
                res.checksum_ok = 1'b1;
            end
            else if (!seg_long)
            begin
                res.checksum_ok = 1'b0;
            end
            else if (seen_wire_cs == CKSUM_ZERO)
            begin
                res.checksum_ok = 1'b1;
            end
            else
            begin
                res.checksum_ok = (cs == CKSUM_ZERO);
            end
            res.checksum = cs;
            seg_open     = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Checksum a sender would place in bytes 6-7 of seg_bytes (which must be
    // zero there): fold over data and pseudo-header, invert, zero as ones.
    function automatic logic [15:0] udp_checksum(input logic [31:0] sa, input logic [31:0] da);
        logic [15:0] acc;
        logic [7:0]  lo;
        int          n;
        int          i;
        acc = '0;
        n   = seg_bytes.size();
        for (i = 0; i < n; i += 2)
        begin
            lo  = (i + 1 < n) ? seg_bytes[i + 1] : 8'h00;
            acc = ones_add(acc, {seg_bytes[i], lo});
        end
        acc = ones_add(acc, sa[31:16]);
        acc = ones_add(acc, sa[15:0]);
        acc = ones_add(acc, da[31:16]);
        acc = ones_add(acc, da[15:0]);
        acc = ones_add(acc, PROTO_UDP);
        acc = ones_add(acc, n[15:0]);
        acc = ~acc;
        return (acc == CKSUM_ZERO) ? CKSUM_ONES : acc;
    endfunction

    // Fill seg_bytes with n random bytes and, if asked and n is at least 8, a UDP
    // header whose length field matches and whose checksum is correct.
    task automatic fill_segment(input int n, input logic well_formed,
                                input logic [31:0] sa, input logic [31:0] da);
        logic [31:0] r;
        logic [15:0] cs;
        int          i;
        seg_bytes.delete();
        for (i = 0; i < n; i++)
        begin
            r = $urandom;
            seg_bytes.push_back(r[7:0]);
        end
        if (well_formed && n >= 8)
        begin
            seg_bytes[4] = n[15:8];
            seg_bytes[5] = n[7:0];
            seg_bytes[6] = 8'h00;
            seg_bytes[7] = 8'h00;
            cs           = udp_checksum(sa, da);
            seg_bytes[6] = cs[15:8];
            seg_bytes[7] = cs[7:0];
        end
    endtask

    // Build one random segment. Mix: valid verify headers, generate traffic,
    // corrupted headers, zero wire checksum, and short/noise segments.
    task automatic make_random_segment(output logic mode, output logic [31:0] sa,
                                       output logic [31:0] da);
        int          kind;
        int          n;
        int          idx;
        logic [31:0] r;
        kind = $urandom_range(0, 99);
        sa   = pick_addr();
        da   = pick_addr();
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(8, 24);
        if (kind < 45)
        begin
            mode = MODE_VERIFY;
            fill_segment(n, 1'b1, sa, da);
        end
        else if (kind < 70)
        begin
            mode = MODE_GEN;
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, 7);
            fill_segment(n, 1'b0, sa, da);
        end
        else if (kind < 80)
        begin
            // flip one bit somewhere in an otherwise valid segment
            mode = MODE_VERIFY;
            fill_segment(n, 1'b1, sa, da);
            idx = $urandom_range(0, n - 1);
            r   = $urandom;
            seg_bytes[idx] = seg_bytes[idx] ^ (8'h01 << r[2:0]);
        end
        else if (kind < 87)
        begin
            // sender did not compute a checksum
            mode = MODE_VERIFY;
            fill_segment(n, 1'b1, sa, da);
            seg_bytes[6] = 8'h00;
            seg_bytes[7] = 8'h00;
        end
        else
        begin
            r    = $urandom;
            mode = r[0];
            fill_segment($urandom_range(1, 7), 1'b0, sa, da);
        end
    endtask

    // Offer one item and hold it until accepted; predict at the accepting edge.
    // With no gap afterward, valid stays high for the caller's next item.
    task automatic send_byte(input ucs_in_t it, input logic gaps_on, input logic typed,
                             input ucs_out_t typed_res);
        logic     produced;
        ucs_out_t res;
        int       g;
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (byte_ready !== 1'b1);
        predict_byte(it, produced, res);
        if (produced)
            sum_expect_q.push_back(typed ? typed_res : res);
        g = gaps_on ? idle_len() : 0;
        if (g > 0)
        begin
            byte_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Send seg_bytes as one segment. Side fields only matter on the first
    // byte, so the rest carry random junk.
    task automatic send_segment(input logic mode, input logic [31:0] sa,
                                input logic [31:0] da, input logic gaps_on);
        ucs_in_t     it;
        logic [31:0] r;
        int          n;
        int          i;
        n = seg_bytes.size();
        for (i = 0; i < n; i++)
        begin
            r = $urandom;
            it.mode      = (i == 0) ? mode : r[0];
            it.src_ip    = (i == 0) ? sa : $urandom;
            it.dst_ip    = (i == 0) ? da : $urandom;
            it.data_byte = seg_bytes[i];
            it.last_byte = (i == n - 1);
            send_byte(it, gaps_on, 1'b0, '0);
        end
    endtask

    // Drop valid and wait for every owed result. At least one edge passes,
    // so valid is never lowered and raised in the same step.
    task automatic drain_results();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (sum_expect_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ucs_out_t want;
        if (rst_n && sum_valid === 1'b1 && sum_ready === 1'b1)
        begin
            if (sum_expect_q.size() == 0)
            begin
                $error("result with nothing expected: checksum %h ok %b",
                       sum_item.checksum, sum_item.checksum_ok);
                fail_count++;
            end
            else
            begin
                want = sum_expect_q.pop_front();
                if (sum_item.checksum !== want.checksum)
                begin
                    $error("checksum: expected %h, actual %h", want.checksum, sum_item.checksum);
                    fail_count++;
                end
                if (sum_item.checksum_ok !== want.checksum_ok)
                begin
                    $error("checksum_ok: expected %b, actual %b",
                           want.checksum_ok, sum_item.checksum_ok);
                    fail_count++;
                end
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready pattern, plus one long hold-off so the fold
    // pipeline fills and the engine pushes back on the byte channel.
    // ------------------------------------------------------------------
    initial
    begin
        logic held;
        int   hi_len;
        int   lo_len;
        held = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 12)
            begin
                held = 1'b1;
                sum_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            hi_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
            sum_ready <= 1'b1;
            repeat (hi_len) @(posedge clk);
            lo_len = idle_len();
            if (lo_len > 0)
            begin
                sum_ready <= 1'b0;
                repeat (lo_len) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic        mode;
        logic [31:0] sa;
        logic [31:0] da;
        logic        paused;
        int          rand_bytes;
        int          i;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (i = 0; i < DIR_ROWS; i++)
            send_byte(dir_table[i].item, 1'b1, dir_table[i].typed, dir_table[i].want);

        // random segments; about a quarter go back to back with no idling
        rand_bytes = 0;
        paused     = 1'b0;
        while (rand_bytes < RAND_BYTES)
        begin
            if (!paused && rand_bytes >= PAUSE_AT)
            begin
                drain_results();    // sender pause with everything owed delivered
                paused = 1'b1;
            end
            make_random_segment(mode, sa, da);
            send_segment(mode, sa, da, $urandom_range(0, 3) != 0);
            rand_bytes += seg_bytes.size();
        end

        drain_results();
        repeat (DRAIN_PAD) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hard limit in case the engine hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
